// ===== src/morse_beacon_keyer_defines.svh =====
// Assertion macros used by the checker of the Morse beacon keyer.
`ifndef MORSE_BEACON_KEYER_DEFINES_SVH
`define MORSE_BEACON_KEYER_DEFINES_SVH

// Same-cycle implication, sampled on i_clk and quiet while i_rst_n is low.
`define MBK_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// Next-cycle implication, sampled on i_clk and quiet while i_rst_n is low.
`define MBK_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

// ===== src/mbk_pkg.sv =====
// Package with the sizes, codes, types and Morse table of the beacon keyer.
package mbk_pkg;

    localparam int MSG_LEN   = 64;
    localparam int CHANNELS  = 2;

    localparam int LEN_W     = $clog2(MSG_LEN + 1);
    localparam int IDX_W     = (MSG_LEN > 1) ? $clog2(MSG_LEN) : 1;
    localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int MSG_DEPTH = CHANNELS * MSG_LEN;
    localparam int MSG_AW    = (MSG_DEPTH > 1) ? $clog2(MSG_DEPTH) : 1;

    localparam int CHAR_W    = 8;
    localparam int GAP_W     = 8;
    localparam int ELEM_W    = 3;
    localparam int TIMER_W   = 2;
    localparam int PAT_W     = 8;

    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_START = 2'd2;

    localparam logic [1:0] CFG_LETTER_GAP   = 2'd0;
    localparam logic [1:0] CFG_WORD_GAP     = 2'd1;
    localparam logic [1:0] CFG_REPEAT_PAUSE = 2'd2;

    localparam logic [GAP_W-1:0]  LETTER_GAP_RST   = 8'd3;
    localparam logic [GAP_W-1:0]  WORD_GAP_RST     = 8'd7;
    localparam logic [GAP_W-1:0]  REPEAT_PAUSE_RST = 8'd100;

    localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'h20;
    localparam int                DAH_BIT    = PAT_W - 1;

    localparam logic [TIMER_W-1:0] DIT_TICKS = 2'd1;
    localparam logic [TIMER_W-1:0] DAH_TICKS = 2'd3;

    typedef struct packed {
        logic                 key_level;
        logic                 enabled;
        logic [TIMER_W-1:0]   element_timer;
        logic [ELEM_W-1:0]    elements_left;
        logic [PAT_W-1:0]     pattern;
        logic [GAP_W-1:0]     gap_count;
        logic [LEN_W-1:0]     char_pos;
        logic [LEN_W-1:0]     msg_len;
    } t_chan_state;

    localparam int STATE_W = $bits(t_chan_state);

    typedef struct packed {
        logic [1:0]        req_type;
        logic              channel;
        logic              ch_ok;
        logic [5:0]        position;
        logic [CHAR_W-1:0] char_code;
        logic [6:0]        msg_length;
    } t_item;

    typedef struct packed {
        logic [GAP_W-1:0] letter_gap;
        logic [GAP_W-1:0] word_gap;
        logic [GAP_W-1:0] repeat_pause;
    } t_gap_cfg;

    typedef struct packed {
        logic        state_we;
        t_chan_state state;
        logic        msg_we;
        logic        carrier_on;
        logic        active;
    } t_step_res;

    typedef struct packed {
        logic              hit;
        logic [ELEM_W-1:0] count;
        logic [PAT_W-1:0]  bits;
    } t_symbol;

    // Elements are read from the top bit down; a one is a dah.
    function automatic t_symbol morse_lookup(input logic [CHAR_W-1:0] c);
        t_symbol s;
        s = '{hit: 1'b1, count: 3'd0, bits: 8'h00};
        unique case (c)
            "A": begin s.count = 3'd2; s.bits = 8'h40; end
            "B": begin s.count = 3'd4; s.bits = 8'h80; end
            "C": begin s.count = 3'd4; s.bits = 8'hA0; end
            "D": begin s.count = 3'd3; s.bits = 8'h80; end
            "E": begin s.count = 3'd1; s.bits = 8'h00; end
            "F": begin s.count = 3'd4; s.bits = 8'h20; end
            "G": begin s.count = 3'd3; s.bits = 8'hC0; end
            "H": begin s.count = 3'd4; s.bits = 8'h00; end
            "I": begin s.count = 3'd2; s.bits = 8'h00; end
            "J": begin s.count = 3'd4; s.bits = 8'h70; end
            "K": begin s.count = 3'd3; s.bits = 8'hA0; end
            "L": begin s.count = 3'd4; s.bits = 8'h40; end
            "M": begin s.count = 3'd2; s.bits = 8'hC0; end
            "N": begin s.count = 3'd2; s.bits = 8'h80; end
            "O": begin s.count = 3'd3; s.bits = 8'hE0; end
            "P": begin s.count = 3'd4; s.bits = 8'h60; end
            "Q": begin s.count = 3'd4; s.bits = 8'hD0; end
            "R": begin s.count = 3'd3; s.bits = 8'h40; end
            "S": begin s.count = 3'd3; s.bits = 8'h00; end
            "T": begin s.count = 3'd1; s.bits = 8'h80; end
            "U": begin s.count = 3'd3; s.bits = 8'h20; end
            "V": begin s.count = 3'd4; s.bits = 8'h10; end
            "W": begin s.count = 3'd3; s.bits = 8'h60; end
            "X": begin s.count = 3'd4; s.bits = 8'h90; end
            "Y": begin s.count = 3'd4; s.bits = 8'hB0; end
            "Z": begin s.count = 3'd4; s.bits = 8'hC0; end
            "0": begin s.count = 3'd5; s.bits = 8'hF8; end
            "1": begin s.count = 3'd5; s.bits = 8'h78; end
            "2": begin s.count = 3'd5; s.bits = 8'h38; end
            "3": begin s.count = 3'd5; s.bits = 8'h18; end
            "4": begin s.count = 3'd5; s.bits = 8'h08; end
            "5": begin s.count = 3'd5; s.bits = 8'h00; end
            "6": begin s.count = 3'd5; s.bits = 8'h80; end
            "7": begin s.count = 3'd5; s.bits = 8'hC0; end
            "8": begin s.count = 3'd5; s.bits = 8'hE0; end
            "9": begin s.count = 3'd5; s.bits = 8'hF0; end
            ".": begin s.count = 3'd6; s.bits = 8'h54; end
            ",": begin s.count = 3'd6; s.bits = 8'hCC; end
            "/": begin s.count = 3'd5; s.bits = 8'h90; end
            "-": begin s.count = 3'd5; s.bits = 8'h88; end
            "~": begin s.count = 3'd5; s.bits = 8'h50; end
            "?": begin s.count = 3'd6; s.bits = 8'h30; end
            "@": begin s.count = 3'd5; s.bits = 8'h28; end
            default: begin s.hit = 1'b0; end
        endcase
        return s;
    endfunction

endpackage

// ===== src/mbk_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module mbk_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 2,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/mbk_step.sv =====
// Per-item update of one channel's keyer state from its state word and message byte.
module mbk_step (
    input  mbk_pkg::t_item       i_item,
    input  mbk_pkg::t_chan_state i_state,
    input  logic [7:0]           i_msg_char,
    input  mbk_pkg::t_gap_cfg    i_cfg,
    output mbk_pkg::t_step_res   o_res
);
    import mbk_pkg::*;

    t_chan_state        nxt;
    t_symbol            sym;
    logic [TIMER_W-1:0] timer_dec;
    logic [LEN_W-1:0]   len_sat;
    logic               pos_ok;

    always_comb begin
        nxt       = i_state;
        sym       = morse_lookup(i_msg_char);
        timer_dec = i_state.element_timer - TIMER_W'(1);
        pos_ok    = int'(i_item.position) < MSG_LEN;
        if (int'(i_item.msg_length) > MSG_LEN) begin
            len_sat = LEN_W'(MSG_LEN);
        end else begin
            len_sat = LEN_W'(i_item.msg_length);
        end

        unique case (i_item.req_type)
            REQ_TICK: begin
                if (i_state.enabled) begin
                    priority if (i_state.gap_count != '0) begin
                        nxt.gap_count = i_state.gap_count - GAP_W'(1);
                    end else if (i_state.elements_left != '0) begin
                        if (i_state.element_timer == '0) begin
                            nxt.key_level     = 1'b1;
                            nxt.element_timer = i_state.pattern[DAH_BIT] ? DAH_TICKS
                                                                         : DIT_TICKS;
                        end else begin
                            nxt.element_timer = timer_dec;
                            if (timer_dec == '0) begin
                                nxt.key_level     = 1'b0;
                                nxt.pattern       = {i_state.pattern[PAT_W-2:0], 1'b0};
                                nxt.elements_left = i_state.elements_left - ELEM_W'(1);
                            end
                        end
                    end else if (i_state.char_pos >= i_state.msg_len) begin
                        nxt.gap_count = i_cfg.repeat_pause;
                        nxt.char_pos  = '0;
                    end else begin
                        if (i_msg_char == SPACE_CHAR) begin
                            nxt.gap_count = i_cfg.word_gap;
                        end else begin
                            if (sym.hit) begin
                                nxt.pattern       = sym.bits;
                                nxt.elements_left = sym.count;
                                nxt.element_timer = '0;
                            end
                            if (i_state.char_pos != '0) begin
                                nxt.gap_count = i_cfg.letter_gap;
                            end
                        end
                        nxt.char_pos = i_state.char_pos + LEN_W'(1);
                    end
                end
            end
            REQ_START: begin
                if (i_item.msg_length != '0) begin
                    nxt.msg_len       = len_sat;
                    nxt.char_pos      = '0;
                    nxt.gap_count     = '0;
                    nxt.elements_left = '0;
                    nxt.element_timer = '0;
                    nxt.key_level     = 1'b0;
                    nxt.enabled       = 1'b1;
                end
            end
            default: begin
            end
        endcase

        o_res.state      = nxt;
        o_res.state_we   = i_item.ch_ok &&
                           (i_item.req_type == REQ_TICK || i_item.req_type == REQ_START);
        o_res.msg_we     = i_item.ch_ok && i_item.req_type == REQ_WRITE && pos_ok;
        o_res.carrier_on = i_item.ch_ok & nxt.key_level;
        o_res.active     = i_item.ch_ok & nxt.enabled;
    end

endmodule

// ===== src/morse_beacon_keyer.sv =====
// Top level of the two-channel Morse beacon keyer with its state and message memories.
//
//  Channel   Direction  Payload (lowest bit first)
//  --------  ---------  ----------------------------------------------------------
//  s_axis    in         tuser: req_type; tdata: channel, position, char_code,
//                       msg_length, zero fill
//  m_axis    out        tdata: out_channel, carrier_on, active, zero fill
//  cfg       in         i_cfg_idx selects the register, i_cfg_data is the value
//
//  An input beat first reads the channel state word, then the message byte at the
//  channel's character position; the write back follows.
//  The result is registered when the compute stage commits, and a new beat can be
//  taken in that same cycle, but not while a beat is still in the state-read stage.
//  A stalled output register holds the pipeline; a new beat is still taken while a
//  finished result waits, as long as the state-read and compute stages are free.
//  Reset clears the control state and channel valid bits; no memory sweep is needed.
module morse_beacon_keyer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,  // channel, position, char_code, msg_length, pad
    input  logic [1:0]  i_s_axis_tuser,  // req_type
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,  // out_channel, carrier_on, active, pad
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data
);
    import mbk_pkg::*;

    t_gap_cfg            r_cfg;
    t_item               in_item;
    logic                in_accept;

    logic                r_s1_valid;
    t_item               r_s1_item;
    logic                r_s2_valid;
    t_item               r_s2_item;
    t_chan_state         r_s2_state;

    logic [STATE_W-1:0]  st_rdata;
    t_chan_state         s1_state;
    logic [CHANNELS-1:0] r_st_vld;
    logic                r_fwd_valid;
    logic [CH_W-1:0]     r_fwd_ch;
    t_chan_state         r_fwd_state;

    logic [CHAR_W-1:0]   msg_rdata;
    logic [MSG_AW-1:0]   msg_raddr;
    logic [MSG_AW-1:0]   msg_waddr;

    t_step_res           res;
    logic                slot_free;
    logic                s2_commit;
    logic                state_we;
    logic                r_out_valid;
    logic [7:0]          r_out_data;

    assign in_item.req_type   = i_s_axis_tuser;
    assign in_item.channel    = i_s_axis_tdata[0];
    assign in_item.ch_ok      = int'(i_s_axis_tdata[0]) < CHANNELS;
    assign in_item.position   = i_s_axis_tdata[6:1];
    assign in_item.char_code  = i_s_axis_tdata[14:7];
    assign in_item.msg_length = i_s_axis_tdata[21:15];

    assign slot_free       = !r_out_valid || i_m_axis_tready;
    assign s2_commit       = r_s2_valid && slot_free;
    assign o_s_axis_tready = !r_s1_valid && (!r_s2_valid || s2_commit);
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;
    assign state_we        = s2_commit && res.state_we;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.letter_gap   <= LETTER_GAP_RST;
            r_cfg.word_gap     <= WORD_GAP_RST;
            r_cfg.repeat_pause <= REPEAT_PAUSE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LETTER_GAP:   r_cfg.letter_gap   <= i_cfg_data;
                CFG_WORD_GAP:     r_cfg.word_gap     <= i_cfg_data;
                CFG_REPEAT_PAUSE: r_cfg.repeat_pause <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    mbk_ram #(
        .WIDTH (STATE_W),
        .DEPTH (CHANNELS)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (state_we),
        .i_waddr (CH_W'(r_s2_item.channel)),
        .i_wdata (res.state),
        .i_re    (in_accept),
        .i_raddr (CH_W'(in_item.channel)),
        .o_rdata (st_rdata)
    );

    // The most recent write back wins over the memory, which it may have missed.
    always_comb begin
        if (!r_s1_item.ch_ok) begin
            s1_state = '0;
        end else if (r_fwd_valid && r_fwd_ch == CH_W'(r_s1_item.channel)) begin
            s1_state = r_fwd_state;
        end else if (r_st_vld[CH_W'(r_s1_item.channel)]) begin
            s1_state = t_chan_state'(st_rdata);
        end else begin
            s1_state = '0;
        end
    end

    assign msg_raddr = MSG_AW'(int'(r_s1_item.channel) * MSG_LEN +
                               int'(s1_state.char_pos[IDX_W-1:0]));
    assign msg_waddr = MSG_AW'(int'(r_s2_item.channel) * MSG_LEN +
                               int'(r_s2_item.position));

    mbk_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (MSG_DEPTH)
    ) u_msg_ram (
        .i_clk   (i_clk),
        .i_we    (s2_commit && res.msg_we),
        .i_waddr (msg_waddr),
        .i_wdata (r_s2_item.char_code),
        .i_re    (r_s1_valid),
        .i_raddr (msg_raddr),
        .o_rdata (msg_rdata)
    );

    mbk_step u_step (
        .i_item     (r_s2_item),
        .i_state    (r_s2_state),
        .i_msg_char (msg_rdata),
        .i_cfg      (r_cfg),
        .o_res      (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_fwd_valid <= 1'b0;
            r_st_vld    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid <= in_accept;
            if (r_s1_valid) begin
                r_s2_valid <= 1'b1;
            end else if (s2_commit) begin
                r_s2_valid <= 1'b0;
            end
            if (state_we) begin
                r_fwd_valid                         <= 1'b1;
                r_st_vld[CH_W'(r_s2_item.channel)] <= 1'b1;
            end
            if (s2_commit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_item <= in_item;
        end
        if (r_s1_valid) begin
            r_s2_item  <= r_s1_item;
            r_s2_state <= s1_state;
        end
        if (state_we) begin
            r_fwd_ch    <= CH_W'(r_s2_item.channel);
            r_fwd_state <= res.state;
        end
        if (s2_commit) begin
            r_out_data <= {5'd0, res.active, res.carrier_on, r_s2_item.channel};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

// ===== src/mbk_checker.sv =====
// Port-level checker of the Morse beacon keyer and its bind to the top level.
`include "morse_beacon_keyer_defines.svh"

module mbk_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        i_s_axis_tready,
    input logic        i_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [7:0]  i_m_axis_tdata
);

    // A stalled result beat keeps its value.
    `MBK_ASSERT_NEXT(a_out_hold, i_m_axis_tvalid && !i_m_axis_tready, i_m_axis_tvalid && $stable(i_m_axis_tdata))

    // The carrier is never keyed on a channel that has not been started.
    `MBK_ASSERT_IMPL(a_carrier_needs_active, i_m_axis_tvalid, !i_m_axis_tdata[1] || i_m_axis_tdata[2])

    // The fill bits of a result beat stay zero.
    `MBK_ASSERT_IMPL(a_out_pad_zero, i_m_axis_tvalid, i_m_axis_tdata[7:3] == 5'd0)

    // The state read of one beat blocks the input for the following cycle.
    `MBK_ASSERT_NEXT(a_one_beat_in_two, i_s_axis_tvalid && i_s_axis_tready, !i_s_axis_tready)

endmodule

bind morse_beacon_keyer mbk_checker u_mbk_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .i_s_axis_tready (o_s_axis_tready),
    .i_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .i_m_axis_tdata  (o_m_axis_tdata)
);
